// File: design/mdlc_pkg.sv
// Shared types, codes and helpers for the multiplexer channel control block.
package mdlc_pkg;

   // Width of the reply timer
   localparam int TIMER_WIDTH = 16;

   // Configuration reset values and fixed signal codes
   localparam logic [7:0]  SIG_RESET     = 8'h0D;
   localparam int          SIG_FC_BIT    = 1;
   localparam logic [7:0]  RETRY_RESET   = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Configuration register indexes
   localparam logic [1:0] CSR_DLC_NUMBER  = 2'd0;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd2;
   localparam logic [1:0] CSR_CLIENT_PORT = 2'd3;

   // Request event codes
   localparam logic [3:0] REQ_CONNECT    = 4'd0;
   localparam logic [3:0] REQ_PARAMNEG   = 4'd1;
   localparam logic [3:0] REQ_DISCONNECT = 4'd2;
   localparam logic [3:0] REQ_FRAME      = 4'd3;
   localparam logic [3:0] REQ_MSC        = 4'd4;
   localparam logic [3:0] REQ_TICK       = 4'd5;
   localparam logic [3:0] REQ_MODEMFLOW  = 4'd6;
   localparam logic [3:0] REQ_WRITE      = 4'd7;
   localparam logic [3:0] REQ_CANCEL     = 4'd8;
   localparam logic [3:0] REQ_CLIENTFLOW = 4'd9;

   // Received frame kind of interest
   localparam logic [2:0] FT_UA = 3'd1;

   // Frame to send
   localparam logic [2:0] SF_NONE     = 3'd0;
   localparam logic [2:0] SF_SABM     = 3'd1;
   localparam logic [2:0] SF_DISC     = 3'd2;
   localparam logic [2:0] SF_PARAMNEG = 3'd3;
   localparam logic [2:0] SF_MSC      = 3'd4;
   localparam logic [2:0] SF_DATA     = 3'd5;

   // Status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ERROR     = 2'd1;
   localparam logic [1:0] STAT_NOT_READY = 2'd2;

   // Write list actions
   localparam logic [1:0] LIST_NONE  = 2'd0;
   localparam logic [1:0] LIST_WAIT  = 2'd1;
   localparam logic [1:0] LIST_WRITE = 2'd2;
   localparam logic [1:0] LIST_PURGE = 2'd3;

   // Channel state reporting codes
   localparam logic [2:0] CODE_DISC          = 3'd0;
   localparam logic [2:0] CODE_CONNECTING    = 3'd1;
   localparam logic [2:0] CODE_PARAMNEG      = 3'd2;
   localparam logic [2:0] CODE_MSCSENT       = 3'd3;
   localparam logic [2:0] CODE_WAITREADY     = 3'd4;
   localparam logic [2:0] CODE_CONNECTED     = 3'd5;
   localparam logic [2:0] CODE_DISCONNECTING = 3'd6;
   localparam logic [2:0] CODE_TXERROR       = 3'd7;

   // Channel state machine, one-hot
   typedef enum logic [7:0] {
      CS_DISC          = 8'b0000_0001,
      CS_CONNECTING    = 8'b0000_0010,
      CS_PARAMNEG      = 8'b0000_0100,
      CS_MSCSENT       = 8'b0000_1000,
      CS_WAITREADY     = 8'b0001_0000,
      CS_CONNECTED     = 8'b0010_0000,
      CS_DISCONNECTING = 8'b0100_0000,
      CS_TXERROR       = 8'b1000_0000
   } chan_state_type;

   // Request payload
   typedef struct packed {
      logic [3:0] req_type;
      logic [2:0] frame_type;
      logic [7:0] signals_in;
      logic       flow_on;
      logic       tx_ok;
      logic       last_port_closed;
   } req_type_s_type;

   // Result payload
   typedef struct packed {
      logic [2:0] send_frame;
      logic [7:0] frame_signals;
      logic [1:0] status;
      logic [2:0] channel_state;
      logic       channel_ready;
      logic [1:0] list_action;
      logic       client_flow_on;
      logic       port_signals_valid;
      logic [7:0] port_signals;
   } rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [5:0]  dlc_number;
      logic [7:0]  retry_limit;
      logic [15:0] timeout_ticks;
      logic        has_client_port;
   } cfg_type;

   // Channel context carried from one request to the next
   typedef struct packed {
      chan_state_type         chan_state;
      logic [7:0]             retries_left;
      logic [TIMER_WIDTH-1:0] reply_timer;
      logic                   timer_running;
      logic                   msc_pending;
      logic [7:0]             local_signals;
      logic                   write_delayed;
      logic                   send_stopped;
      logic                   modem_stopped;
      logic                   ready_flag;
   } ctx_type;

   // Timer reload: timeout clamped to the timer range and at least one
   function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [15:0] ticks);
      localparam int LW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
      logic [LW-1:0] ext;
      logic [LW-1:0] lim;
      ext = LW'(ticks);
      lim = LW'({TIMER_WIDTH{1'b1}});
      if (ext > lim) ext = lim;
      if (ext == '0) ext = LW'(1);
      return TIMER_WIDTH'(ext);
   endfunction

   // Map the one-hot state to its reporting code
   function automatic logic [2:0] state_code(input chan_state_type st);
      logic [2:0] code;
      case (st)
         CS_DISC:          code = CODE_DISC;
         CS_CONNECTING:    code = CODE_CONNECTING;
         CS_PARAMNEG:      code = CODE_PARAMNEG;
         CS_MSCSENT:       code = CODE_MSCSENT;
         CS_WAITREADY:     code = CODE_WAITREADY;
         CS_CONNECTED:     code = CODE_CONNECTED;
         CS_DISCONNECTING: code = CODE_DISCONNECTING;
         CS_TXERROR:       code = CODE_TXERROR;
         default:          code = CODE_DISC;
      endcase
      return code;
   endfunction

endpackage

// File: design/mdlc_step.sv
// Next channel context and result for one request.
module mdlc_step (
   input  mdlc_pkg::ctx_type        cur,
   input  mdlc_pkg::cfg_type        cfg,
   input  mdlc_pkg::req_type_s_type req,
   output mdlc_pkg::ctx_type        nxt,
   output mdlc_pkg::rsp_type        rsp
);
   import mdlc_pkg::*;

   logic [TIMER_WIDTH-1:0] load;
   logic [7:0]             new_sig;
   logic                   fc_stop;
   logic [2:0]             frame;
   logic [7:0]             fsig;
   logic [1:0]             status;
   logic [1:0]             list;
   logic                   pvalid;
   logic [7:0]             psig;

   assign load = timer_load(cfg.timeout_ticks);

   // Apply the request to the channel context
   always_comb begin
      nxt     = cur;
      frame   = SF_NONE;
      fsig    = 8'h00;
      status  = STAT_OK;
      list    = LIST_NONE;
      pvalid  = 1'b0;
      psig    = 8'h00;
      new_sig = cur.local_signals;
      fc_stop = req.signals_in[SIG_FC_BIT];

      case (req.req_type)
         REQ_CONNECT: begin
            if (cur.chan_state != CS_CONNECTED) begin
               frame = SF_SABM;
               if (req.tx_ok) begin
                  nxt.chan_state    = CS_CONNECTING;
                  nxt.reply_timer   = load;
                  nxt.timer_running = 1'b1;
                  nxt.retries_left  = cfg.retry_limit;
               end else begin
                  status = STAT_ERROR;
               end
            end else begin
               status = STAT_ERROR;
            end
         end
         REQ_PARAMNEG: begin
            if (cur.chan_state != CS_CONNECTED) begin
               frame = SF_PARAMNEG;
               if (req.tx_ok) begin
                  nxt.chan_state    = CS_PARAMNEG;
                  nxt.reply_timer   = load;
                  nxt.timer_running = 1'b1;
                  nxt.retries_left  = cfg.retry_limit;
               end else begin
                  status = STAT_ERROR;
               end
            end
         end
         REQ_DISCONNECT: begin
            if (cur.chan_state == CS_CONNECTED) begin
               frame = SF_DISC;
               if (req.tx_ok) begin
                  nxt.chan_state    = CS_DISCONNECTING;
                  nxt.ready_flag    = 1'b0;
                  nxt.reply_timer   = '0;
                  nxt.timer_running = 1'b0;
               end else begin
                  status = STAT_ERROR;
               end
            end else if (cur.chan_state != CS_TXERROR) begin
               status = STAT_ERROR;
            end
         end
         REQ_FRAME: begin
            if (req.frame_type == FT_UA) begin
               nxt.reply_timer   = '0;
               nxt.timer_running = 1'b0;
               if (cur.chan_state == CS_CONNECTING) begin
                  // Follow the UA with an MSC command unless one is outstanding
                  if (!cur.msc_pending) begin
                     frame = SF_MSC;
                     fsig  = cur.local_signals;
                     if (req.tx_ok) begin
                        nxt.reply_timer   = load;
                        nxt.timer_running = 1'b1;
                        nxt.retries_left  = cfg.retry_limit;
                        nxt.msc_pending   = 1'b1;
                        nxt.chan_state    = CS_MSCSENT;
                     end
                  end
               end else if (cur.chan_state == CS_DISCONNECTING) begin
                  nxt.chan_state = CS_DISC;
                  if (req.last_port_closed) nxt.ready_flag = 1'b1;
               end
            end
         end
         REQ_MSC: begin
            if (cur.msc_pending) begin
               nxt.msc_pending   = 1'b0;
               nxt.reply_timer   = '0;
               nxt.timer_running = 1'b0;
               if (cur.chan_state == CS_MSCSENT) begin
                  if (cfg.has_client_port) begin
                     nxt.chan_state = CS_WAITREADY;
                  end else begin
                     nxt.chan_state = CS_CONNECTED;
                     nxt.ready_flag = 1'b1;
                  end
               end
               // Forward changed modem signals to the client port
               if (cfg.dlc_number != 6'd0 && cur.local_signals != req.signals_in &&
                   cfg.has_client_port) begin
                  list             = fc_stop ? LIST_WAIT : LIST_WRITE;
                  nxt.send_stopped = fc_stop;
                  if (!fc_stop && cur.write_delayed) begin
                     frame = SF_DATA;
                     if (req.tx_ok) nxt.write_delayed = 1'b0;
                  end
                  pvalid = 1'b1;
                  psig   = req.signals_in;
               end
            end
         end
         REQ_TICK: begin
            if (cur.timer_running) begin
               if (cur.reply_timer > TIMER_WIDTH'(1)) begin
                  nxt.reply_timer = cur.reply_timer - TIMER_WIDTH'(1);
               end else if (cur.retries_left > 8'd1) begin
                  // Retransmit the outstanding command and restart the timer
                  nxt.retries_left  = cur.retries_left - 8'd1;
                  nxt.reply_timer   = load;
                  nxt.timer_running = 1'b1;
                  if (cur.msc_pending) begin
                     frame           = SF_MSC;
                     fsig            = cur.local_signals;
                     nxt.msc_pending = req.tx_ok;
                     if (req.tx_ok) nxt.retries_left = cfg.retry_limit;
                  end else if (cur.chan_state == CS_PARAMNEG) begin
                     frame = SF_PARAMNEG;
                  end else if (cur.chan_state == CS_CONNECTING) begin
                     frame = SF_SABM;
                  end else if (cur.chan_state == CS_DISCONNECTING) begin
                     frame = SF_DISC;
                  end
               end else begin
                  // Retries exhausted
                  nxt.retries_left  = 8'd0;
                  nxt.msc_pending   = 1'b0;
                  nxt.reply_timer   = '0;
                  nxt.timer_running = 1'b0;
                  nxt.chan_state    = CS_TXERROR;
                  nxt.ready_flag    = 1'b1;
               end
            end
         end
         REQ_MODEMFLOW: begin
            if (req.flow_on != cur.modem_stopped &&
                req.flow_on != cur.local_signals[SIG_FC_BIT]) begin
               new_sig             = cur.local_signals;
               new_sig[SIG_FC_BIT] = req.flow_on;
               if (cur.msc_pending) begin
                  status = STAT_NOT_READY;
               end else begin
                  nxt.local_signals = new_sig;
                  frame             = SF_MSC;
                  fsig              = new_sig;
                  if (req.tx_ok) begin
                     nxt.reply_timer   = load;
                     nxt.timer_running = 1'b1;
                     nxt.retries_left  = cfg.retry_limit;
                     nxt.msc_pending   = 1'b1;
                     nxt.modem_stopped = req.flow_on;
                  end else begin
                     status = STAT_ERROR;
                  end
               end
            end
         end
         REQ_WRITE: begin
            if (cur.send_stopped) begin
               nxt.write_delayed = 1'b1;
            end else if (cur.chan_state == CS_CONNECTED) begin
               frame = SF_DATA;
               if (!req.tx_ok) status = STAT_ERROR;
            end
         end
         REQ_CANCEL: begin
            nxt.write_delayed = 1'b0;
            list              = LIST_PURGE;
         end
         REQ_CLIENTFLOW: begin
            nxt.send_stopped = req.flow_on;
            if (!req.flow_on && cur.write_delayed) begin
               frame = SF_DATA;
               if (req.tx_ok) nxt.write_delayed = 1'b0;
            end
         end
         default: begin
            status = STAT_ERROR;
         end
      endcase
   end

   // Assemble the result from the updated context
   always_comb begin
      rsp.send_frame         = frame;
      rsp.frame_signals      = fsig;
      rsp.status             = status;
      rsp.channel_state      = state_code(nxt.chan_state);
      rsp.channel_ready      = nxt.ready_flag;
      rsp.list_action        = list;
      rsp.client_flow_on     = nxt.send_stopped;
      rsp.port_signals_valid = pvalid;
      rsp.port_signals       = psig;
   end

endmodule

// File: design/mux_dlc_channel_control.sv
// Control machine of one multiplexer logical channel.
// A request is captured in the input register and its result in the result register.
// Throughput: one request per cycle while the result side does not stall; the input register feeds the
// channel context update and the result register.
// Reset (synchronous, active high): channel disconnected, timer stopped,
// configuration at its default values, both pipeline stages empty.
module mux_dlc_channel_control (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mdlc_pkg::req_type_s_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mdlc_pkg::rsp_type        rsp_data,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);
   import mdlc_pkg::*;

   cfg_type        cfg_ff;
   ctx_type        ctx_ff;
   ctx_type        ctx_in;
   logic           in_valid_ff;
   req_type_s_type in_req_ff;
   logic           out_valid_ff;
   rsp_type        out_rsp_ff;
   rsp_type        out_rsp_in;
   logic           advance;

   // Move the held request on when the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dlc_number      <= 6'd0;
         cfg_ff.retry_limit     <= RETRY_RESET;
         cfg_ff.timeout_ticks   <= TIMEOUT_RESET;
         cfg_ff.has_client_port <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_DLC_NUMBER:  cfg_ff.dlc_number      <= csr_wdata[5:0];
            CSR_RETRY_LIMIT: cfg_ff.retry_limit     <= csr_wdata[7:0];
            CSR_TIMEOUT:     cfg_ff.timeout_ticks   <= csr_wdata;
            CSR_CLIENT_PORT: cfg_ff.has_client_port <= csr_wdata[0];
            default:         cfg_ff.dlc_number      <= cfg_ff.dlc_number;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_req_ff <= req_data;
   end

   // Channel context update
   mdlc_step u_step (
      .cur (ctx_ff),
      .cfg (cfg_ff),
      .req (in_req_ff),
      .nxt (ctx_in),
      .rsp (out_rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.chan_state    <= CS_DISC;
         ctx_ff.retries_left  <= 8'd0;
         ctx_ff.reply_timer   <= '0;
         ctx_ff.timer_running <= 1'b0;
         ctx_ff.msc_pending   <= 1'b0;
         ctx_ff.local_signals <= SIG_RESET;
         ctx_ff.write_delayed <= 1'b0;
         ctx_ff.send_stopped  <= 1'b0;
         ctx_ff.modem_stopped <= 1'b0;
         ctx_ff.ready_flag    <= 1'b0;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) out_rsp_ff <= out_rsp_in;
   end

endmodule

// File: dv/mux_dlc_channel_control_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multiplexer channel control block.
module mux_dlc_channel_control_tb;
   import mdlc_pkg::*;

   localparam int          QUIET_LIMIT   = 2000;
   localparam int          HOLD_CYCLES   = 80;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          PRINT_LIMIT   = 200;
   localparam int          PHASE_ITEMS   = 200;
   localparam logic [31:0] TIMER_MAX     = 32'((64'd1 << TIMER_WIDTH) - 64'd1);
   localparam logic [3:0]  REQ_UNDEFINED = 4'd15;
   localparam logic [2:0]  FT_UNDEFINED  = 3'd7;

   // DUT ports
   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   req_type_s_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   rsp_type        rsp_data;
   logic           csr_write = 1'b0;
   logic [1:0]     csr_index = '0;
   logic [15:0]    csr_wdata = '0;

   // Request and expected result queues, counters
   req_type_s_type req_q[$];
   rsp_type        result_q[$];
   int             req_pushed = 0;
   int             req_accepted = 0;
   int             rsp_checked = 0;
   int             mismatch_count = 0;
   int             settings_count = 0;
   int             txerr_count = 0;
   int             quiet_cycles = 0;
   int             hold_left = 0;
   int             next_hold_at = 200;
   int             tx_idle_pct = 0;
   int             rx_idle_pct = 0;
   logic [7:0]     states_seen = '0;

   // Channel model: configuration and context
   cfg_type                cfg;
   logic [2:0]             ch_state;
   logic [7:0]             ch_retries;
   logic [TIMER_WIDTH-1:0] ch_timer;
   logic                   ch_timer_on;
   logic                   ch_msc_wait;
   logic [7:0]             ch_sigs;
   logic                   ch_write_held;
   logic                   ch_tx_stopped;
   logic                   ch_modem_stopped;
   logic                   ch_ready;
   rsp_type                pend;

   mux_dlc_channel_control u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- model

   task automatic reset_channel_model();
      cfg.dlc_number      = '0;
      cfg.retry_limit     = RETRY_RESET;
      cfg.timeout_ticks   = TIMEOUT_RESET;
      cfg.has_client_port = 1'b0;
      ch_state         = CODE_DISC;
      ch_retries       = '0;
      ch_timer         = '0;
      ch_timer_on      = 1'b0;
      ch_msc_wait      = 1'b0;
      ch_sigs          = SIG_RESET;
      ch_write_held    = 1'b0;
      ch_tx_stopped    = 1'b0;
      ch_modem_stopped = 1'b0;
      ch_ready         = 1'b0;
   endtask

   task automatic stop_reply_timer();
      ch_timer    = '0;
      ch_timer_on = 1'b0;
   endtask

   // Load the timeout, clamped to the timer range and at least one tick
   task automatic arm_reply_timer();
      logic [31:0] load;
      load = 32'(cfg.timeout_ticks);
      if (load > TIMER_MAX) load = TIMER_MAX;
      if (load == 32'd0) load = 32'd1;
      ch_timer    = TIMER_WIDTH'(load);
      ch_timer_on = 1'b1;
   endtask

   // Issue an MSC command; refuse while one is still unanswered
   task automatic send_modem_status(input logic [7:0] sig, input logic ok,
                                    output logic [1:0] st);
      if (ch_msc_wait) begin
         st = STAT_NOT_READY;
      end else begin
         ch_sigs            = sig;
         pend.send_frame    = SF_MSC;
         pend.frame_signals = sig;
         if (!ok) begin
            st = STAT_ERROR;
         end else begin
            arm_reply_timer();
            ch_retries  = cfg.retry_limit;
            ch_msc_wait = 1'b1;
            st          = STAT_OK;
         end
      end
   endtask

   // Update the client stop state; release a held write on resume
   task automatic set_client_flow(input logic stop, input logic ok);
      ch_tx_stopped = stop;
      if (!stop && ch_write_held) begin
         pend.send_frame = SF_DATA;
         if (ok) ch_write_held = 1'b0;
      end
   endtask

   // Retransmit the pending command or give up once retries run out
   task automatic reply_timeout(input logic ok);
      logic [1:0] st;
      if (ch_retries > 8'd1) begin
         ch_retries = ch_retries - 8'd1;
         if (ch_msc_wait) begin
            ch_msc_wait = 1'b0;
            send_modem_status(ch_sigs, ok, st);
         end else if (ch_state == CODE_PARAMNEG) begin
            pend.send_frame = SF_PARAMNEG;
         end else if (ch_state == CODE_CONNECTING) begin
            pend.send_frame = SF_SABM;
         end else if (ch_state == CODE_DISCONNECTING) begin
            pend.send_frame = SF_DISC;
         end
         arm_reply_timer();
      end else begin
         ch_retries  = '0;
         ch_msc_wait = 1'b0;
         stop_reply_timer();
         ch_state    = CODE_TXERROR;
         ch_ready    = 1'b1;
         txerr_count++;
      end
   endtask

   // Advance the channel model by one request and build the expected result
   task automatic predict_channel(input req_type_s_type rq);
      logic [7:0] v;
      logic       do_send;
      logic [1:0] st;
      logic       stop;
      pend = '0;
      case (rq.req_type)
         REQ_CONNECT: begin
            if (ch_state != CODE_CONNECTED) begin
               pend.send_frame = SF_SABM;
               if (rq.tx_ok) begin
                  ch_state = CODE_CONNECTING;
                  arm_reply_timer();
                  ch_retries = cfg.retry_limit;
               end else begin
                  pend.status = STAT_ERROR;
               end
            end else begin
               pend.status = STAT_ERROR;
            end
         end
         REQ_PARAMNEG: begin
            if (ch_state != CODE_CONNECTED) begin
               pend.send_frame = SF_PARAMNEG;
               if (rq.tx_ok) begin
                  ch_state = CODE_PARAMNEG;
                  arm_reply_timer();
                  ch_retries = cfg.retry_limit;
               end else begin
                  pend.status = STAT_ERROR;
               end
            end
         end
         REQ_DISCONNECT: begin
            if (ch_state == CODE_CONNECTED) begin
               pend.send_frame = SF_DISC;
               if (rq.tx_ok) begin
                  ch_state = CODE_DISCONNECTING;
                  ch_ready = 1'b0;
                  stop_reply_timer();
               end else begin
                  pend.status = STAT_ERROR;
               end
            end else if (ch_state != CODE_TXERROR) begin
               pend.status = STAT_ERROR;
            end
         end
         REQ_FRAME: begin
            if (rq.frame_type == FT_UA) begin
               stop_reply_timer();
               if (ch_state == CODE_CONNECTING) begin
                  send_modem_status(ch_sigs, rq.tx_ok, st);
                  if (st == STAT_OK) ch_state = CODE_MSCSENT;
               end else if (ch_state == CODE_DISCONNECTING) begin
                  ch_state = CODE_DISC;
                  if (rq.last_port_closed) ch_ready = 1'b1;
               end
            end
         end
         REQ_MSC: begin
            if (ch_msc_wait) begin
               ch_msc_wait = 1'b0;
               stop_reply_timer();
               if (ch_state == CODE_MSCSENT) begin
                  ch_state = CODE_WAITREADY;
                  if (!cfg.has_client_port) begin
                     ch_state = CODE_CONNECTED;
                     ch_ready = 1'b1;
                  end
               end
               if (cfg.dlc_number != '0 && ch_sigs != rq.signals_in &&
                   cfg.has_client_port) begin
                  stop = rq.signals_in[SIG_FC_BIT];
                  pend.list_action = stop ? LIST_WAIT : LIST_WRITE;
                  set_client_flow(stop, rq.tx_ok);
                  pend.port_signals_valid = 1'b1;
                  pend.port_signals       = rq.signals_in;
               end
            end
         end
         REQ_TICK: begin
            if (ch_timer_on) begin
               if (ch_timer > TIMER_WIDTH'(1)) ch_timer = ch_timer - TIMER_WIDTH'(1);
               else reply_timeout(rq.tx_ok);
            end
         end
         REQ_MODEMFLOW: begin
            if (rq.flow_on != ch_modem_stopped) begin
               v       = ch_sigs;
               do_send = 1'b0;
               if (rq.flow_on) begin
                  if (!v[SIG_FC_BIT]) begin
                     v[SIG_FC_BIT] = 1'b1;
                     do_send       = 1'b1;
                  end
               end else if (v[SIG_FC_BIT]) begin
                  v[SIG_FC_BIT] = 1'b0;
                  do_send       = 1'b1;
               end
               if (do_send) begin
                  send_modem_status(v, rq.tx_ok, st);
                  pend.status = st;
                  if (st == STAT_OK) ch_modem_stopped = rq.flow_on;
               end
            end
         end
         REQ_WRITE: begin
            if (ch_tx_stopped) begin
               ch_write_held = 1'b1;
            end else if (ch_state == CODE_CONNECTED) begin
               pend.send_frame = SF_DATA;
               if (!rq.tx_ok) pend.status = STAT_ERROR;
            end
         end
         REQ_CANCEL: begin
            ch_write_held    = 1'b0;
            pend.list_action = LIST_PURGE;
         end
         REQ_CLIENTFLOW: begin
            set_client_flow(rq.flow_on, rq.tx_ok);
         end
         default: begin
            pend.status = STAT_ERROR;
         end
      endcase
      pend.channel_state  = ch_state;
      pend.channel_ready  = ch_ready;
      pend.client_flow_on = ch_tx_stopped;
   endtask

   // ------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("ERROR at %0t ns, result %0d: %s", $time, rsp_checked, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input int unsigned got_v,
                                input int unsigned want_v);
      if (got_v != want_v)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got_v, want_v));
   endtask

   // Compare one result against the oldest expectation
   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (result_q.size() == 0) begin
         report_mismatch("result with no request outstanding");
      end else begin
         want = result_q.pop_front();
         rsp_checked++;
         states_seen[want.channel_state] = 1'b1;
         compare_field("send_frame", got.send_frame, want.send_frame);
         compare_field("frame_signals", got.frame_signals, want.frame_signals);
         compare_field("status", got.status, want.status);
         compare_field("channel_state", got.channel_state, want.channel_state);
         compare_field("channel_ready", got.channel_ready, want.channel_ready);
         compare_field("list_action", got.list_action, want.list_action);
         compare_field("client_flow_on", got.client_flow_on, want.client_flow_on);
         compare_field("port_signals_valid", got.port_signals_valid,
                       want.port_signals_valid);
         compare_field("port_signals", got.port_signals, want.port_signals);
      end
   endtask

   // ------------------------------------------------------------- stimulus

   function automatic req_type_s_type make_req(input logic [3:0] kind,
                                               input logic [2:0] ft,
                                               input logic [7:0] sig,
                                               input logic flow, input logic ok,
                                               input logic last);
      req_type_s_type r;
      r.req_type         = kind;
      r.frame_type       = ft;
      r.signals_in       = sig;
      r.flow_on          = flow;
      r.tx_ok            = ok;
      r.last_port_closed = last;
      return r;
   endfunction

   // Random content for a given event; transmits mostly succeed
   function automatic req_type_s_type rand_req(input logic [3:0] kind);
      return make_req(kind, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0,
                      1'($urandom_range(0, 1)));
   endfunction

   // MSC reply: half random signals, half close to the local byte
   function automatic req_type_s_type msc_reply();
      req_type_s_type r;
      r = rand_req(REQ_MSC);
      if ($urandom_range(0, 1) != 0)
         r.signals_in = SIG_RESET | (8'($urandom_range(0, 1)) << SIG_FC_BIT);
      return r;
   endfunction

   function automatic req_type_s_type body_req();
      req_type_s_type r;
      case ($urandom_range(0, 6))
         0, 1:    r = rand_req(REQ_WRITE);
         2:       r = rand_req(REQ_CLIENTFLOW);
         3:       r = rand_req(REQ_MODEMFLOW);
         4:       r = msc_reply();
         5:       r = rand_req(REQ_CANCEL);
         default: r = rand_req(REQ_TICK);
      endcase
      return r;
   endfunction

   task automatic offer(input req_type_s_type r);
      req_q.push_back(r);
      req_pushed++;
   endtask

   // One channel lifetime: open, MSC exchange, traffic, close
   task automatic queue_session();
      req_type_s_type r;
      if ($urandom_range(0, 4) == 0) offer(rand_req(REQ_PARAMNEG));
      offer(rand_req(REQ_CONNECT));
      repeat ($urandom_range(0, 3)) offer(rand_req(REQ_TICK));
      r = rand_req(REQ_FRAME);
      r.frame_type = FT_UA;
      offer(r);
      repeat ($urandom_range(0, 2)) offer(rand_req(REQ_TICK));
      offer(msc_reply());
      repeat ($urandom_range(2, 8)) offer(body_req());
      offer(rand_req(REQ_DISCONNECT));
      repeat ($urandom_range(0, 2)) offer(rand_req(REQ_TICK));
      r = rand_req(REQ_FRAME);
      r.frame_type = FT_UA;
      offer(r);
   endtask

   task automatic queue_random_traffic(input int n);
      int start;
      start = req_pushed;
      while (req_pushed - start < n) begin
         if ($urandom_range(0, 99) < 20) offer(rand_req(4'($urandom_range(0, 15))));
         else queue_session();
      end
   endtask

   // Hold until every request is in and answered, then let the pipe settle
   task automatic wait_drained();
      while (req_accepted != req_pushed || result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Half the traffic, a full pause until everything is answered, the rest
   task automatic mixed_traffic(input int n);
      queue_random_traffic(n / 2);
      wait_drained();
      queue_random_traffic(n - n / 2);
      wait_drained();
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct <= tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   // Write all four registers; only called while the block is idle
   task automatic program_channel(input logic [5:0] dlc, input logic [7:0] retries,
                                  input logic [15:0] ticks, input logic client);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_DLC_NUMBER;
      csr_wdata <= 16'(dlc);
      @(posedge clock);
      csr_index <= CSR_RETRY_LIMIT;
      csr_wdata <= 16'(retries);
      @(posedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= ticks;
      @(posedge clock);
      csr_index <= CSR_CLIENT_PORT;
      csr_wdata <= 16'(client);
      @(posedge clock);
      csr_write <= 1'b0;
      cfg.dlc_number      = dlc;
      cfg.retry_limit     = retries;
      cfg.timeout_ticks   = ticks;
      cfg.has_client_port = client;
      settings_count++;
   endtask

   // Request driver: hold while stalled, otherwise offer the next request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_channel(req_data);
            result_q.push_back(pend);
            req_accepted++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= req_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor: check accepted results, drive stall with long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_checked >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 450;
            rsp_stall    <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
         end
      end
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                  quiet_cycles, result_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence
   initial begin
      reset_channel_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: top channel, two transmissions, zero timeout, client port
      program_channel(6'd63, 8'd2, 16'd0, 1'b1);
      set_idling(16, 74);
      offer(make_req(REQ_UNDEFINED, FT_UNDEFINED, 8'hFF, 1'b1, 1'b1, 1'b1));
      offer(make_req(REQ_FRAME, FT_UNDEFINED, 8'h00, 1'b0, 1'b0, 1'b0));
      offer(make_req(REQ_CONNECT, FT_UA, 8'h00, 1'b0, 1'b0, 1'b0));
      offer(make_req(REQ_CONNECT, FT_UA, 8'hFF, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_TICK, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_TICK, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_DISCONNECT, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_PARAMNEG, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_TICK, FT_UA, 8'h00, 1'b0, 1'b0, 1'b0));
      offer(make_req(REQ_CONNECT, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_FRAME, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_MODEMFLOW, FT_UA, 8'h00, 1'b1, 1'b1, 1'b0));
      offer(make_req(REQ_MSC, FT_UA, 8'hF2, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_MSC, FT_UA, 8'hF2, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_WRITE, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_CLIENTFLOW, FT_UA, 8'h00, 1'b0, 1'b0, 1'b0));
      offer(make_req(REQ_CLIENTFLOW, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_CANCEL, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_MODEMFLOW, FT_UA, 8'h00, 1'b1, 1'b0, 1'b0));
      mixed_traffic(PHASE_ITEMS);

      // Directed: control channel, single transmission, no client port
      program_channel(6'd0, 8'd1, 16'd3, 1'b0);
      offer(make_req(REQ_CONNECT, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_FRAME, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_MSC, FT_UA, SIG_RESET, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_WRITE, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_WRITE, FT_UA, 8'h00, 1'b0, 1'b0, 1'b0));
      offer(make_req(REQ_CONNECT, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_PARAMNEG, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_DISCONNECT, FT_UA, 8'h00, 1'b0, 1'b0, 1'b0));
      offer(make_req(REQ_DISCONNECT, FT_UA, 8'h00, 1'b0, 1'b1, 1'b0));
      offer(make_req(REQ_FRAME, FT_UA, 8'h00, 1'b0, 1'b1, 1'b1));
      mixed_traffic(PHASE_ITEMS);

      // Receiver mostly ready, sender sparse
      program_channel(6'd1, 8'd255, 16'd1, 1'b1);
      set_idling(74, 16);
      mixed_traffic(PHASE_ITEMS);
      program_channel(6'($urandom_range(1, 62)), 8'($urandom_range(2, 6)),
                      16'($urandom_range(1, 6)), 1'b1);
      mixed_traffic(PHASE_ITEMS);

      // Full rate on both sides
      program_channel(6'd5, 8'd3, 16'd65535, 1'b1);
      set_idling(0, 0);
      mixed_traffic(PHASE_ITEMS);
      program_channel(6'($urandom_range(0, 63)), 8'($urandom_range(1, 4)), 16'd2,
                      1'($urandom_range(0, 1)));
      mixed_traffic(PHASE_ITEMS);

      if (result_q.size() != 0) report_mismatch("expected results left over at end");
      $display("Run: %0d requests, %0d results checked, %0d register settings",
               req_pushed, rsp_checked, settings_count);
      $display("Channel states reached %08b, retry exhaustions %0d, errors %0d",
               states_seen, txerr_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
